### rtl/core/kalman_angle_filter_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Kalman angle filter unit
// Concurrent assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_FILTER_UNIT_ASSERT_SVH
`define KALMAN_ANGLE_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KAF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KAF_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KAF_ASSERT(label, clk, rst, prop, msg)
`define KAF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/kaf_pkg.sv
// ---------------------------------------------------------------------------
// Kalman angle filter package
// Shared constants, types and helpers for the angle filter core.
// ---------------------------------------------------------------------------
package kaf_pkg;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int COV_FRAC_BITS_DEF   = 24;
  localparam int DT_FRAC_BITS        = 16;
  localparam int DATA_W              = 32;
  localparam int IN_W                = 25;
  localparam int DT_W                = 16;
  localparam int CFG_IDX_W           = 2;
  localparam logic [31:0] ANGLE_NOISE_RESET = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RESET  = 32'd50332;
  localparam logic [31:0] MEAS_NOISE_RESET  = 32'd503316;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Operand request for the shared multiplier.
  typedef struct packed {
    logic               start;
    logic signed [34:0] a;
    logic signed [33:0] b;
    logic [5:0]         shift;
  } mul_req_t;

  // Division request.
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [33:0] den;
  } div_req_t;

  // Saturate a 66-bit signed value to 32 bits, flag set on clipping.
  function automatic logic [32:0] sat32(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction
endpackage

### rtl/core/kalman_angle_filter_unit.sv
// ---------------------------------------------------------------------------
// Kalman angle filter unit
// Two-state angle and gyro-bias Kalman filter on a shared multiplier and
// divider under a small sequencer.
// ---------------------------------------------------------------------------
// An update with a positive innovation variance runs ten products on the
// shared multiplier, each issued by the sequencer and handed back through
// its wait state, and two 57-step quotients on the restoring divider, then
// presents the result through the output state. When the innovation variance
// is not positive the quotients are skipped. A load goes straight to the
// output state to present its result. The input is not ready while an item
// is in work or a result waits; the result holds until taken.
module kalman_angle_filter_unit
  import kaf_pkg::*;
#(
  parameter int COV_FRAC_BITS   = COV_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action [0]
  input  logic [0:0]           s_axis_tuser,
  // measured_angle [24:0], measured_rate [49:25], time_step [65:50], zeros
  input  logic [71:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // saturated [0]
  output logic [0:0]           m_axis_tuser,
  // filtered_angle [31:0]
  output logic [31:0]          m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);
`include "kalman_angle_filter_unit_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_DTR, ST_M_DTP11, ST_M_INNER, ST_M_BIASN, ST_DIV0, ST_DIV1,
    ST_M_K0Y, ST_M_K1Y, ST_M_K0T0, ST_M_K0T1, ST_M_K1T0, ST_M_K1T1,
    ST_WAIT, ST_OUT
  } state_t;

  state_t state;
  state_t after_wait;
  logic [31:0] angle_noise, bias_noise, meas_noise;
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [31:0] k0, k1, y, t00, t01;
  logic signed [24:0] meas_a;
  logic [15:0] dt;
  logic clip;
  mul_req_t mreq;
  div_req_t dreq;
  logic mdone, ddone;
  logic signed [65:0] mres, dres;
  logic signed [33:0] s_sum;

  kaf_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .result(mres));
  kaf_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dres));

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign s_sum = 34'(p00) + 34'($signed({2'b00, meas_noise}));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RESET;
      bias_noise  <= BIAS_NOISE_RESET;
      meas_noise  <= MEAS_NOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_BIAS_NOISE:  bias_noise  <= cfg_data;
        REG_MEAS_NOISE:  meas_noise  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: each product state but the last issues a request, then waits.
  always_ff @(posedge clk) begin
    logic [32:0] sv, a1, a2;
    if (rst) begin
      state <= ST_IDLE;
      after_wait <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      mreq <= '0;
      dreq <= '0;
      angle <= '0; bias <= '0; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      clip <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            meas_a <= s_axis_tdata[24:0];
            dt     <= s_axis_tdata[65:50];
            if (s_axis_tuser[0] == ACT_LOAD) begin
              angle <= 32'($signed(s_axis_tdata[24:0]));
              clip  <= 1'b0;
              state <= ST_OUT;
            end else begin
              sv = sat32(66'($signed(s_axis_tdata[49:25])) - 66'(bias));
              clip <= sv[32];
              mreq <= '{1'b1, 35'($signed(sv[31:0])), 34'({1'b0, s_axis_tdata[65:50]}),
                        6'(DT_FRAC_BITS)};
              after_wait <= ST_M_DTR;
              state <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          mreq.start <= 1'b0;
          if (mdone) state <= after_wait;
        end
        ST_M_DTR: begin
          sv = sat32(66'(angle) + mres);
          angle <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(p11), 34'({1'b0, dt}), 6'(DT_FRAC_BITS)};
          after_wait <= ST_M_DTP11; state <= ST_WAIT;
        end
        ST_M_DTP11: begin
          // inner = dt*p11 - p01 - p10 + q_angle, fits in 35 bits
          mreq <= '{1'b1, 35'(mres - 66'(p01) - 66'(p10) + 66'({1'b0, angle_noise})),
                    34'({1'b0, dt}), 6'(DT_FRAC_BITS)};
          sv = sat32(66'(p01) - mres); p01 <= sv[31:0]; a1 = sv;
          sv = sat32(66'(p10) - mres); p10 <= sv[31:0]; a2 = sv;
          clip <= clip | a1[32] | a2[32];
          after_wait <= ST_M_INNER; state <= ST_WAIT;
        end
        ST_M_INNER: begin
          sv = sat32(66'(p00) + mres);
          p00 <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'({1'b0, bias_noise}), 34'({1'b0, dt}), 6'(DT_FRAC_BITS)};
          after_wait <= ST_M_BIASN; state <= ST_WAIT;
        end
        ST_M_BIASN: begin
          sv = sat32(66'(p11) + mres);
          p11 <= sv[31:0]; a1 = sv;
          sv = sat32(66'($signed(meas_a)) - 66'(angle));
          y <= sv[31:0]; clip <= clip | a1[32] | sv[32];
          t01 <= p01;
          if (s_sum > 34'sd0) begin
            dreq <= '{1'b1, p00, s_sum};
            state <= ST_DIV0;
          end else begin
            k0 <= '0; k1 <= '0;
            mreq <= '{1'b1, 35'sd0, 34'sd0, 6'(COV_FRAC_BITS)};
            after_wait <= ST_M_K0Y; state <= ST_WAIT;
          end
        end
        ST_DIV0: begin
          if (ddone) begin
            sv = sat32(dres); k0 <= sv[31:0]; clip <= clip | sv[32];
            dreq <= '{1'b1, p10, s_sum};
            state <= ST_DIV1;
          end else begin
            dreq.start <= 1'b0;
          end
        end
        ST_DIV1: begin
          if (ddone) begin
            sv = sat32(dres); k1 <= sv[31:0]; clip <= clip | sv[32];
            mreq <= '{1'b1, 35'(k0), 34'(y), 6'(COV_FRAC_BITS)};
            after_wait <= ST_M_K0Y; state <= ST_WAIT;
          end else begin
            dreq.start <= 1'b0;
          end
        end
        ST_M_K0Y: begin
          t00 <= p00;
          sv = sat32(66'(angle) + mres);
          angle <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(k1), 34'(y), 6'(COV_FRAC_BITS)};
          after_wait <= ST_M_K1Y; state <= ST_WAIT;
        end
        ST_M_K1Y: begin
          sv = sat32(66'(bias) + mres);
          bias <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(k0), 34'(t00), 6'(COV_FRAC_BITS)};
          after_wait <= ST_M_K0T0; state <= ST_WAIT;
        end
        ST_M_K0T0: begin
          sv = sat32(66'(p00) - mres);
          p00 <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(k0), 34'(t01), 6'(COV_FRAC_BITS)};
          after_wait <= ST_M_K0T1; state <= ST_WAIT;
        end
        ST_M_K0T1: begin
          sv = sat32(66'(p01) - mres);
          p01 <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(k1), 34'(t00), 6'(COV_FRAC_BITS)};
          after_wait <= ST_M_K1T0; state <= ST_WAIT;
        end
        ST_M_K1T0: begin
          sv = sat32(66'(p10) - mres);
          p10 <= sv[31:0]; clip <= clip | sv[32];
          mreq <= '{1'b1, 35'(k1), 34'(t01), 6'(COV_FRAC_BITS)};
          after_wait <= ST_M_K1T1; state <= ST_WAIT;
        end
        ST_M_K1T1: begin
          sv = sat32(66'(p11) - mres);
          p11 <= sv[31:0]; clip <= clip | sv[32];
          state <= ST_OUT;
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = angle;
  assign m_axis_tuser = clip;

  // Checks on the sequencer.
  `KAF_ASSERT(a_no_accept_busy, clk, rst, (state != ST_IDLE) |-> !s_axis_tready, "accept while busy")
  `KAF_ASSERT(a_out_after_seq, clk, rst, $rose(m_axis_tvalid) |-> $past(state == ST_OUT), "result without sequence")
  `KAF_ASSERT(a_result_holds, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed under stall")
endmodule

### rtl/core/kaf_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier with rounding shift
// Signed 35x34 product from two 35x17 partial products, then
// floor(p / 2^n + 1/2).
// ---------------------------------------------------------------------------
module kaf_mul
  import kaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  output logic               done,
  output logic signed [65:0] result
);
  logic signed [34:0] a_reg;
  logic signed [33:0] b_reg;
  logic [5:0]         shift_reg;
  logic signed [67:0] acc;
  logic [1:0]         phase;
  logic signed [67:0] part;
  logic signed [67:0] rnd;

  // Low half first (unsigned digit), then the signed high half.
  always_comb begin
    if (phase == 2'd1) begin
      part = 68'(a_reg) * $signed({1'b0, b_reg[16:0]});
    end else begin
      part = (68'(a_reg) * 68'($signed(b_reg[33:17]))) <<< 17;
    end
    rnd = acc + (68'sd1 <<< (shift_reg - 6'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_reg     <= req.a;
        b_reg     <= req.b;
        shift_reg <= req.shift;
        acc       <= '0;
        phase     <= 2'd1;
      end else if (phase == 2'd1) begin
        acc   <= part;
        phase <= 2'd2;
      end else if (phase == 2'd2) begin
        acc   <= acc + part;
        phase <= 2'd3;
      end else if (phase == 2'd3) begin
        result <= 66'(rnd >>> shift_reg);
        done   <= 1'b1;
        phase  <= 2'd0;
      end
    end
  end
endmodule

### rtl/core/kaf_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Signed quotient truncated toward zero, its sign taken from the numerator alone, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kaf_div
  import kaf_pkg::*;
#(
  parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic signed [65:0] quotient
);
  localparam int NW = 32 + COV_FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_mag;
  logic [33:0]   den_mag;
  logic [34:0]   rem;
  logic [NW-1:0] quo;
  logic          neg;
  logic [CW-1:0] count;
  logic          busy;
  logic [34:0]   trial;

  assign trial = {rem[33:0], num_mag[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num_mag <= NW'(req.num[31] ? -(NW'($signed(req.num))) : NW'(req.num))
                   << COV_FRAC_BITS;
        den_mag <= req.den[33] ? 34'(-req.den) : 34'(req.den);
        neg     <= req.num[31];
        rem     <= '0;
        quo     <= '0;
        count   <= CW'(NW);
        busy    <= 1'b1;
      end else if (busy) begin
        // One restoring step per cycle.
        num_mag <= num_mag << 1;
        if (trial >= {1'b0, den_mag}) begin
          rem <= trial - {1'b0, den_mag};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -66'($signed({1'b0, quo})) : 66'($signed({1'b0, quo}));
endmodule
